// ===== src/rae_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rae_pkg
// Shared widths, codes and a saturation helper for the range aggregate engine.
// ----------------------------------------------------------------------------
package rae_pkg;

  localparam int VALUE_W = 32;
  localparam int SUM_W = 46;
  localparam int OP_W = 3;
  localparam int KIND_W = 2;
  localparam int MAX_RANGE_CELLS_DEF = 16384;

  localparam logic [OP_W-1:0] OP_SUM = 3'd0;
  localparam logic [OP_W-1:0] OP_AVG = 3'd1;
  localparam logic [OP_W-1:0] OP_MIN = 3'd2;
  localparam logic [OP_W-1:0] OP_MAX = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT = 3'd4;

  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd1;

  localparam logic signed [VALUE_W-1:0] Q_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] Q_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // clamp a wide signed sum to the q15.16 range
  function automatic value_t sat_sum(input sum_t s);
    logic upper_same;
    upper_same = (s[SUM_W-1:VALUE_W-1] == {(SUM_W-VALUE_W+1){1'b0}}) ||
                 (s[SUM_W-1:VALUE_W-1] == {(SUM_W-VALUE_W+1){1'b1}});
    if (upper_same) begin
      return s[VALUE_W-1:0];
    end else if (s[SUM_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

// ===== src/rae_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rae_front
// Takes one cell per cycle when accepted; keeps the running sum, count, min,
// max and error flag of the open run; hands a summary on at the last cell.
// ----------------------------------------------------------------------------
module rae_front #(
  parameter int MAX_RANGE_CELLS = rae_pkg::MAX_RANGE_CELLS_DEF,
  parameter int CNT_W = $clog2(MAX_RANGE_CELLS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [rae_pkg::OP_W-1:0]     operation,
  input  logic [rae_pkg::KIND_W-1:0]   cell_kind,
  input  logic signed [rae_pkg::VALUE_W-1:0] cell_value,
  input  logic                         last_cell,
  output logic                         sum_push,
  output logic signed [rae_pkg::SUM_W-1:0]   sum_total,
  output logic [CNT_W-1:0]             sum_count,
  output logic signed [rae_pkg::VALUE_W-1:0] sum_min,
  output logic signed [rae_pkg::VALUE_W-1:0] sum_max,
  output logic                         sum_error,
  output logic [rae_pkg::OP_W-1:0]     sum_op
);
  import rae_pkg::*;

  sum_t running_sum, running_sum_next;
  logic [CNT_W-1:0] number_count, number_count_next;
  value_t running_min, running_min_next;
  value_t running_max, running_max_next;
  logic sticky_error, sticky_error_next;
  logic [OP_W-1:0] latched_operation, latched_operation_next;
  logic in_run;

  sum_t base_sum;
  logic [CNT_W-1:0] base_count;
  value_t base_min, base_max;
  logic base_error;
  logic signed [SUM_W:0] sum_ext;

  always_comb begin
    // a fresh run starts from cleared accumulators
    base_sum = in_run ? running_sum : '0;
    base_count = in_run ? number_count : '0;
    base_min = in_run ? running_min : Q_MAX;
    base_max = in_run ? running_max : Q_MIN;
    base_error = in_run ? sticky_error : 1'b0;
    latched_operation_next = in_run ? latched_operation : operation;

    sum_ext = (SUM_W+1)'(base_sum) + (SUM_W+1)'(cell_value);
    running_sum_next = base_sum;
    number_count_next = base_count;
    running_min_next = base_min;
    running_max_next = base_max;
    sticky_error_next = base_error;

    if (cell_kind == KIND_NUMBER) begin
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
        running_sum_next = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
        running_sum_next = sum_ext[SUM_W-1:0];
      end
      if (base_count < CNT_W'(MAX_RANGE_CELLS)) begin
        number_count_next = base_count + 1'b1;
      end
      if (cell_value < base_min) begin
        running_min_next = cell_value;
      end
      if (cell_value > base_max) begin
        running_max_next = cell_value;
      end
    end else if (cell_kind != KIND_EMPTY) begin
      sticky_error_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
      latched_operation <= '0;
      sticky_error <= 1'b0;
      number_count <= '0;
      running_sum <= '0;
      running_min <= Q_MAX;
      running_max <= Q_MIN;
    end else if (accept) begin
      in_run <= !last_cell;
      latched_operation <= latched_operation_next;
      sticky_error <= sticky_error_next;
      number_count <= number_count_next;
      running_sum <= running_sum_next;
      running_min <= running_min_next;
      running_max <= running_max_next;
    end
  end

  assign sum_push = accept && last_cell;
  assign sum_total = running_sum_next;
  assign sum_count = number_count_next;
  assign sum_min = running_min_next;
  assign sum_max = running_max_next;
  assign sum_error = sticky_error_next;
  assign sum_op = latched_operation_next;

endmodule

// ===== src/rae_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rae_queue
// Small first-in first-out buffer of run summaries between front and back.
// ----------------------------------------------------------------------------
module rae_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);
  import rae_pkg::*;

  logic [WIDTH-1:0] slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic do_push, do_pop;

  assign full = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign do_push = push && !full;
  assign do_pop = pop && valid;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== src/rae_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rae_back
// Turns a run summary into the result, with a one-bit-per-cycle divider for
// the average, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module rae_back #(
  parameter int MAX_RANGE_CELLS = rae_pkg::MAX_RANGE_CELLS_DEF,
  parameter int CNT_W = $clog2(MAX_RANGE_CELLS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sum_valid,
  output logic                         sum_pop,
  input  logic signed [rae_pkg::SUM_W-1:0]   sum_total,
  input  logic [CNT_W-1:0]             sum_count,
  input  logic signed [rae_pkg::VALUE_W-1:0] sum_min,
  input  logic signed [rae_pkg::VALUE_W-1:0] sum_max,
  input  logic                         sum_error,
  input  logic [rae_pkg::OP_W-1:0]     sum_op,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [rae_pkg::VALUE_W-1:0] result_value,
  output logic                         result_error
);
  import rae_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_DIV = 1'b1;

  logic state;
  logic out_valid;
  logic slot_free;
  logic start_div;
  logic direct_load;
  logic div_done;

  logic [SUM_W-1:0] div_q;
  logic [CNT_W-1:0] div_rem;
  logic [CNT_W-1:0] div_den;
  logic div_neg;
  logic [STEP_W-1:0] div_cnt;

  logic [CNT_W:0] rem_shift;
  logic rem_ge;
  logic [SUM_W-1:0] sum_mag;

  value_t direct_value;
  logic direct_error;
  value_t avg_value;

  assign slot_free = !out_valid || pop;
  assign start_div = (state == S_IDLE) && sum_valid && slot_free &&
                     (sum_op == OP_AVG) && !sum_error && (sum_count != '0);
  assign direct_load = (state == S_IDLE) && sum_valid && slot_free && !start_div;
  assign sum_pop = start_div || direct_load;
  assign div_done = (state == S_DIV) && (div_cnt == '0);

  assign sum_mag = sum_total[SUM_W-1] ? SUM_W'(-sum_total) : SUM_W'(sum_total);
  assign rem_shift = {div_rem, div_q[SUM_W-1]};
  assign rem_ge = rem_shift >= {1'b0, div_den};

  // results that need no division
  always_comb begin
    direct_value = '0;
    direct_error = sum_error;
    if (!sum_error) begin
      case (sum_op)
        OP_SUM: direct_value = sat_sum(sum_total);
        OP_AVG: direct_value = '0;
        OP_MIN: begin
          direct_error = (sum_count == '0);
          direct_value = direct_error ? '0 : sum_min;
        end
        OP_MAX: begin
          direct_error = (sum_count == '0);
          direct_value = direct_error ? '0 : sum_max;
        end
        OP_COUNT: direct_value = VALUE_W'(sum_count) << 16;
        default: direct_error = 1'b1;
      endcase
    end
  end

  // apply sign to the quotient magnitude and clamp
  always_comb begin
    if (div_neg) begin
      if (div_q > SUM_W'({1'b1, {(VALUE_W-1){1'b0}}})) begin
        avg_value = Q_MIN;
      end else begin
        avg_value = VALUE_W'(-div_q);
      end
    end else if (div_q > SUM_W'(Q_MAX)) begin
      avg_value = Q_MAX;
    end else begin
      avg_value = div_q[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      div_q <= sum_mag;
      div_rem <= '0;
      div_den <= sum_count;
      div_neg <= sum_total[SUM_W-1];
    end else if (state == S_DIV && div_cnt != '0) begin
      div_q <= {div_q[SUM_W-2:0], rem_ge};
      div_rem <= rem_ge ? CNT_W'(rem_shift - {1'b0, div_den}) : CNT_W'(rem_shift);
    end
  end

  always_ff @(posedge clk) begin
    if (direct_load) begin
      result_value <= direct_value;
      result_error <= direct_error;
    end else if (div_done) begin
      result_value <= avg_value;
      result_error <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      div_cnt <= '0;
    end else begin
      if (direct_load || div_done) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start_div) begin
            state <= S_DIV;
            div_cnt <= STEP_W'(SUM_W);
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            state <= S_IDLE;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign empty = !out_valid;

endmodule

// ===== src/range_aggregate_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_aggregate_engine
// Streaming sum / average / min / max / count over runs of typed cells.
// ----------------------------------------------------------------------------
// Cells go in on a queue-style port: an item is taken when push is high and
// full is low. The operation is read on the first cell of a run; last_cell
// closes the run. Results come out on a queue-style port: result_value and
// result_error are valid while empty is low and are taken on pop.
// The front takes one cell per cycle while full is low, so runs stream with
// no gaps. On the last cell the run summary goes into a two-entry queue; the
// back takes it when its output is free. An average is worked out by a
// divider in the back (load, then one quotient bit per cycle from a 46-bit
// dividend, then finish); every other operation is loaded into the result
// register directly.
// When the result is not taken, the back holds it and the queue fills; full
// rises once both queue entries hold finished runs, stopping the input.
// Synchronous reset empties the queue and output and closes any open run.
// ----------------------------------------------------------------------------
module range_aggregate_engine #(
  parameter int MAX_RANGE_CELLS = rae_pkg::MAX_RANGE_CELLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [rae_pkg::OP_W-1:0]           operation,
  input  logic [rae_pkg::KIND_W-1:0]         cell_kind,
  input  logic signed [rae_pkg::VALUE_W-1:0] cell_value,
  input  logic                               last_cell,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [rae_pkg::VALUE_W-1:0] result_value,
  output logic                               result_error
);
  import rae_pkg::*;

  localparam int CNT_W = $clog2(MAX_RANGE_CELLS + 1);
  localparam int Q_W = SUM_W + CNT_W + 2 * VALUE_W + 1 + OP_W;

  logic accept;
  logic f_push;
  sum_t f_total;
  logic [CNT_W-1:0] f_count;
  value_t f_min, f_max;
  logic f_error;
  logic [OP_W-1:0] f_op;

  logic q_full, q_valid, q_pop;
  logic [Q_W-1:0] q_in, q_out;

  assign full = q_full;
  assign accept = push && !q_full;

  rae_front #(
    .MAX_RANGE_CELLS(MAX_RANGE_CELLS),
    .CNT_W(CNT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (operation),
    .cell_kind  (cell_kind),
    .cell_value (cell_value),
    .last_cell  (last_cell),
    .sum_push   (f_push),
    .sum_total  (f_total),
    .sum_count  (f_count),
    .sum_min    (f_min),
    .sum_max    (f_max),
    .sum_error  (f_error),
    .sum_op     (f_op)
  );

  assign q_in = {f_total, f_count, f_min, f_max, f_error, f_op};

  rae_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  rae_back #(
    .MAX_RANGE_CELLS(MAX_RANGE_CELLS),
    .CNT_W(CNT_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .sum_valid    (q_valid),
    .sum_pop      (q_pop),
    .sum_total    (q_out[Q_W-1 -: SUM_W]),
    .sum_count    (q_out[Q_W-SUM_W-1 -: CNT_W]),
    .sum_min      (q_out[2*VALUE_W+OP_W : VALUE_W+OP_W+1]),
    .sum_max      (q_out[VALUE_W+OP_W : OP_W+1]),
    .sum_error    (q_out[OP_W]),
    .sum_op       (q_out[OP_W-1:0]),
    .empty        (empty),
    .pop          (pop),
    .result_value (result_value),
    .result_error (result_error)
  );

endmodule
